/* rtl/core/tcb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcb_pkg;

   localparam int SIZE_W      = 32;
   localparam int ID_W        = 16;
   localparam int KIND_W      = 2;
   localparam int ERR_W       = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int MAX_CHUNKS  = 63;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GROUP_THRESHOLD    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATE_THRESHOLD = 1'd1;

   localparam logic [SIZE_W-1:0] GROUP_THRESHOLD_RESET    = '0;
   localparam logic [SIZE_W-1:0] SEPARATE_THRESHOLD_RESET = '1;

   // chunk kinds
   localparam logic [KIND_W-1:0] KIND_WHOLE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SPLIT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MEMBER = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd3;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_THRESHOLDS = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 2'd2;

   typedef struct packed {
      logic [SIZE_W-1:0] quotient;
      logic [SIZE_W-1:0] remainder;
   } div_result_type;

endpackage : tcb_pkg

`default_nettype wire

/* rtl/core/tcb_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tcb_req_if import tcb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   object_id;
   logic [SIZE_W-1:0] object_size;
   logic              final_object;

   modport source (output valid, output object_id, output object_size,
                   output final_object, input ready);
   modport sink   (input valid, input object_id, input object_size,
                   input final_object, output ready);
endinterface : tcb_req_if

interface tcb_rsp_if import tcb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   chunk_object;
   logic [SIZE_W-1:0] chunk_offset;
   logic [SIZE_W-1:0] chunk_length;
   logic [KIND_W-1:0] chunk_kind;
   logic              bucket_end;
   logic [ERR_W-1:0]  error_code;
   logic              last_result;

   modport source (output valid, output chunk_object, output chunk_offset,
                   output chunk_length, output chunk_kind, output bucket_end,
                   output error_code, output last_result, input ready);
   modport sink   (input valid, input chunk_object, input chunk_offset,
                   input chunk_length, input chunk_kind, input bucket_end,
                   input error_code, input last_result, output ready);
endinterface : tcb_rsp_if

`default_nettype wire

/* rtl/core/transfer_chunk_bucketizer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | role   | payload                                         | handshake
// ----------+--------+-------------------------------------------------+------------
// req_bus   | sink   | object_id, object_size, final_object            | valid/ready
// rsp_bus   | source | chunk_object/offset/length/kind, bucket_end,    | valid/ready
//           |        | error_code, last_result                         |
// csr_*     | write  | csr_index selects register, csr_write_data      | write_en
//
// one word in flight: a grouped, whole or rejected object is accepted, then
// evaluated; a split object adds two passes of the shared bit-serial divider
// (chunk count, then chunk size), then emits its chunks in order as rsp_bus takes them
// reset is synchronous and clears control state and the group total
// a stalled rsp_bus holds the output register; a new word is taken while
// the last result of the previous one still waits there
module transfer_chunk_bucketizer_unit import tcb_pkg::*; #(
   parameter int MaxChunks = MAX_CHUNKS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_write_data,
   tcb_req_if.sink                   req_bus,
   tcb_rsp_if.source                 rsp_bus
);

   localparam int CountWidth = $clog2(MaxChunks + 1);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_EVAL      = 7'b0000010,
      ST_DIV_COUNT = 7'b0000100,
      ST_DIV_PIECE = 7'b0001000,
      ST_EMIT      = 7'b0010000,
      ST_ERROR     = 7'b0100000,
      ST_FLUSH     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [SIZE_W-1:0] gth_ff, gth_in;
   logic [SIZE_W-1:0] sth_ff, sth_in;

   // group bucket state
   logic [SIZE_W:0]   total_ff, total_in;
   logic              open_ff, open_in;

   // captured word
   logic [ID_W-1:0]   id_ff, id_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              fin_ff, fin_in;

   // split bookkeeping
   logic [SIZE_W-1:0]     piece_ff, piece_in;
   logic [SIZE_W-1:0]     off_ff, off_in;
   logic [CountWidth-1:0] remain_ff, remain_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   out_obj_ff, out_obj_in;
   logic [SIZE_W-1:0] out_off_ff, out_off_in;
   logic [SIZE_W-1:0] out_len_ff, out_len_in;
   logic [KIND_W-1:0] out_kind_ff, out_kind_in;
   logic              out_bend_ff, out_bend_in;
   logic [ERR_W-1:0]  out_err_ff, out_err_in;
   logic              out_last_ff, out_last_in;

   // divider
   logic              div_start;
   logic [SIZE_W-1:0] div_divisor;
   logic              div_done;
   div_result_type    div_res;

   logic              slot_free;
   logic              flush_pend;
   logic              bad_thresh;
   logic [SIZE_W:0]   grp_sum;
   logic              grp_close;
   logic [SIZE_W:0]   cnt_sum;
   logic              too_many;

   tcb_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (size_ff),
      .divisor  (div_divisor),
      .done     (div_done),
      .result   (div_res)
   );

   assign slot_free  = !rsp_valid_ff || rsp_bus.ready;
   assign flush_pend = fin_ff && open_ff;
   assign bad_thresh = (gth_ff > sth_ff) || (sth_ff == '0);
   assign grp_sum    = total_ff + {1'b0, size_ff};
   assign grp_close  = (grp_sum >= {1'b0, gth_ff}) || fin_ff;
   // ceil of size over separate threshold
   assign cnt_sum    = {1'b0, div_res.quotient}
                       + (SIZE_W+1)'(div_res.remainder != '0);
   assign too_many   = cnt_sum > (SIZE_W+1)'(MaxChunks);

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      gth_in       = gth_ff;
      sth_in       = sth_ff;
      total_in     = total_ff;
      open_in      = open_ff;
      id_in        = id_ff;
      size_in      = size_ff;
      fin_in       = fin_ff;
      piece_in     = piece_ff;
      off_in       = off_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_obj_in   = out_obj_ff;
      out_off_in   = out_off_ff;
      out_len_in   = out_len_ff;
      out_kind_in  = out_kind_ff;
      out_bend_in  = out_bend_ff;
      out_err_in   = out_err_ff;
      out_last_in  = out_last_ff;
      div_start    = 1'b0;
      div_divisor  = sth_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GROUP_THRESHOLD:    gth_in = csr_write_data;
            CSR_SEPARATE_THRESHOLD: sth_in = csr_write_data;
            default:                gth_in = gth_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               id_in    = req_bus.object_id;
               size_in  = req_bus.object_size;
               fin_in   = req_bus.final_object;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (bad_thresh) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  out_obj_in   = id_ff;
                  out_off_in   = '0;
                  out_len_in   = '0;
                  out_kind_in  = KIND_WHOLE;
                  out_bend_in  = 1'b0;
                  out_err_in   = ERR_THRESHOLDS;
                  out_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (size_ff < gth_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  out_obj_in   = id_ff;
                  out_off_in   = '0;
                  out_len_in   = size_ff;
                  out_kind_in  = KIND_MEMBER;
                  out_bend_in  = grp_close;
                  out_err_in   = ERR_NONE;
                  out_last_in  = 1'b1;
                  total_in     = grp_close ? '0 : grp_sum;
                  open_in      = !grp_close;
                  state_in     = ST_IDLE;
               end
            end else if (size_ff < sth_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  out_obj_in   = id_ff;
                  out_off_in   = '0;
                  out_len_in   = size_ff;
                  out_kind_in  = KIND_WHOLE;
                  out_bend_in  = 1'b1;
                  out_err_in   = ERR_NONE;
                  out_last_in  = !flush_pend;
                  state_in     = flush_pend ? ST_FLUSH : ST_IDLE;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_COUNT;
            end
         end
         ST_DIV_COUNT: begin
            if (div_done) begin
               if (too_many) begin
                  state_in = ST_ERROR;
               end else begin
                  remain_in   = cnt_sum[CountWidth-1:0];
                  div_start   = 1'b1;
                  div_divisor = SIZE_W'(cnt_sum[CountWidth-1:0]);
                  state_in    = ST_DIV_PIECE;
               end
            end
         end
         ST_DIV_PIECE: begin
            div_divisor = SIZE_W'(remain_ff);
            if (div_done) begin
               piece_in = div_res.quotient;
               off_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_obj_in   = id_ff;
               out_off_in   = off_ff;
               out_kind_in  = KIND_SPLIT;
               out_bend_in  = 1'b1;
               out_err_in   = ERR_NONE;
               off_in       = off_ff + piece_ff;
               remain_in    = remain_ff - 1'b1;
               // last chunk carries whatever the even pieces left over
               if (remain_ff == CountWidth'(1)) begin
                  out_len_in  = size_ff - off_ff;
                  out_last_in = !flush_pend;
                  state_in    = flush_pend ? ST_FLUSH : ST_IDLE;
               end else begin
                  out_len_in  = piece_ff;
                  out_last_in = 1'b0;
               end
            end
         end
         ST_ERROR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_obj_in   = id_ff;
               out_off_in   = '0;
               out_len_in   = '0;
               out_kind_in  = KIND_WHOLE;
               out_bend_in  = 1'b0;
               out_err_in   = ERR_TOO_MANY;
               out_last_in  = !flush_pend;
               state_in     = flush_pend ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               out_obj_in   = '0;
               out_off_in   = '0;
               out_len_in   = total_ff[SIZE_W-1:0];
               out_kind_in  = KIND_FLUSH;
               out_bend_in  = 1'b1;
               out_err_in   = ERR_NONE;
               out_last_in  = 1'b1;
               total_in     = '0;
               open_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gth_ff       <= GROUP_THRESHOLD_RESET;
         sth_ff       <= SEPARATE_THRESHOLD_RESET;
         total_ff     <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gth_ff       <= gth_in;
         sth_ff       <= sth_in;
         total_ff     <= total_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      size_ff     <= size_in;
      fin_ff      <= fin_in;
      piece_ff    <= piece_in;
      off_ff      <= off_in;
      remain_ff   <= remain_in;
      out_obj_ff  <= out_obj_in;
      out_off_ff  <= out_off_in;
      out_len_ff  <= out_len_in;
      out_kind_ff <= out_kind_in;
      out_bend_ff <= out_bend_in;
      out_err_ff  <= out_err_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.chunk_object = out_obj_ff;
   assign rsp_bus.chunk_offset = out_off_ff;
   assign rsp_bus.chunk_length = out_len_ff;
   assign rsp_bus.chunk_kind   = out_kind_ff;
   assign rsp_bus.bucket_end   = out_bend_ff;
   assign rsp_bus.error_code   = out_err_ff;
   assign rsp_bus.last_result  = out_last_ff;

endmodule : transfer_chunk_bucketizer_unit

`default_nettype wire

/* rtl/core/tcb_serial_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module tcb_serial_div import tcb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SIZE_W-1:0] dividend,
   input  wire logic [SIZE_W-1:0] divisor,
   output logic                   done,
   output div_result_type         result
);

   localparam int CNT_W = $clog2(SIZE_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SIZE_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SIZE_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] dvs_ff, dvs_in;
   logic [SIZE_W:0]   shifted;
   logic [SIZE_W:0]   diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[SIZE_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   // partial remainder stays below twice the divisor, so the borrow decides
   assign fits    = !diff[SIZE_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         quo_in = {quo_ff[SIZE_W-2:0], fits};
         rem_in = fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done             = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule : tcb_serial_div

`default_nettype wire

/* rtl/core/tcb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcb_checker import tcb_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [ID_W-1:0]   chunk_object,
   input wire logic [SIZE_W-1:0] chunk_offset,
   input wire logic [SIZE_W-1:0] chunk_length,
   input wire logic [KIND_W-1:0] chunk_kind,
   input wire logic              bucket_end,
   input wire logic [ERR_W-1:0]  error_code,
   input wire logic              last_result
);

   // word held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // no word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // error words carry no chunk
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code != ERR_NONE |->
         chunk_offset == '0 && chunk_length == '0 &&
         chunk_kind == KIND_WHOLE && !bucket_end)
      else $error("error word with chunk content");

   // flush marker closes the group and ends the word's results
   a_flush_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && chunk_kind == KIND_FLUSH |->
         chunk_object == '0 && bucket_end && last_result &&
         error_code == ERR_NONE)
      else $error("malformed flush marker");

   // whole objects and split pieces are their own bucket
   a_own_bucket: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code == ERR_NONE &&
      (chunk_kind == KIND_WHOLE || chunk_kind == KIND_SPLIT) |-> bucket_end)
      else $error("whole or split chunk left bucket open");

endmodule : tcb_checker

bind transfer_chunk_bucketizer_unit tcb_checker u_tcb_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .chunk_object (rsp_bus.chunk_object),
   .chunk_offset (rsp_bus.chunk_offset),
   .chunk_length (rsp_bus.chunk_length),
   .chunk_kind   (rsp_bus.chunk_kind),
   .bucket_end   (rsp_bus.bucket_end),
   .error_code   (rsp_bus.error_code),
   .last_result  (rsp_bus.last_result)
);

`default_nettype wire
